[hw/rtl/affine_matrix4_inverse_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the affine matrix inverse
// Clocked on clk_i and held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef AFFINE_MATRIX4_INVERSE_ASSERT_SVH
`define AFFINE_MATRIX4_INVERSE_ASSERT_SVH

// check the consequent in the same cycle
`define AMI_ASSERT_NOW(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error("assertion failed");

// check the consequent in the next cycle
`define AMI_ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error("assertion failed");

`endif

[hw/rtl/ami_pkg.sv]
// ----------------------------------------------------------------------------
// Affine matrix inverse package
// Shared constants, row codes, lane control and cofactor index tables.
// ----------------------------------------------------------------------------
package ami_pkg;

  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned EPS_BITS      = 32;
  localparam logic [EPS_BITS-1:0] EPS_RESET = 32'd4295;
  localparam int unsigned LANES = 3;
  localparam int unsigned ROWS  = 4;

  typedef enum logic [1:0] {
    ROW_X = 2'd0,
    ROW_Y = 2'd1,
    ROW_Z = 2'd2,
    ROW_T = 2'd3
  } row_e;

  typedef struct packed {
    logic valid;
    row_e row;
    logic sing;
  } ctl_t;

  // adjugate entry k = 3*row + col: sign * (a[i0]*a[i1] - a[i2]*a[i3])
  localparam logic [3:0] ADJ_IDX [9][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7},
    '{4'd1, 4'd8, 4'd2, 4'd7},
    '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd3, 4'd8, 4'd5, 4'd6},
    '{4'd0, 4'd8, 4'd2, 4'd6},
    '{4'd0, 4'd5, 4'd2, 4'd3},
    '{4'd3, 4'd7, 4'd4, 4'd6},
    '{4'd0, 4'd7, 4'd1, 4'd6},
    '{4'd0, 4'd4, 4'd1, 4'd3}
  };
  localparam logic ADJ_NEG [9] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

  // triple products: pair product index, third entry, sign
  localparam logic [4:0] TRI_PROD [6] = '{5'd16, 5'd4, 5'd11, 5'd5, 5'd17, 5'd10};
  localparam logic [3:0] TRI_ELEM [6] = '{4'd8, 4'd6, 4'd7, 4'd6, 4'd8, 4'd7};
  localparam logic TRI_NEG [6] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1};

endpackage

[hw/rtl/ami_front.sv]
// ----------------------------------------------------------------------------
// Affine matrix inverse front end
// Pipelined products, adjugate, determinant, translation sums and the
// relative singularity test.
// ----------------------------------------------------------------------------
module ami_front #(
  parameter int unsigned WORD_BITS = ami_pkg::WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = ami_pkg::FRAC_BITS_DEF,
  localparam int unsigned AW  = 2 * WORD_BITS + 1,
  localparam int unsigned DW  = 3 * WORD_BITS + 4,
  localparam int unsigned TSW = 3 * WORD_BITS + 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic signed [WORD_BITS-1:0]    a_i [9],
  input  logic signed [WORD_BITS-1:0]    c_i [3],
  input  logic [ami_pkg::EPS_BITS-1:0]   eps_i,
  output logic                           out_valid_o,
  output logic                           sing_o,
  output logic signed [AW-1:0]           adj_o [9],
  output logic signed [TSW-1:0]          t_o [3],
  output logic signed [DW-1:0]           det_o
);

  localparam int unsigned W   = WORD_BITS;
  localparam int unsigned PW  = 2 * W;
  localparam int unsigned TLW = 2 * W + 1;
  localparam int unsigned TW  = 3 * W + 1;
  localparam int unsigned MW  = 3 * W + 2;
  localparam int unsigned EB  = ami_pkg::EPS_BITS;
  localparam int unsigned NCH = (DW + EB - 1) / EB;
  localparam int unsigned RW  = NCH * EB + EB;

  logic [7:0] vld_q;

  logic signed [W-1:0]   a1_q [9];
  logic signed [W-1:0]   a2_q [9];
  logic signed [W-1:0]   c1_q [3];
  logic signed [W-1:0]   c2_q [3];
  logic signed [W-1:0]   c3_q [3];
  logic signed [PW-1:0]  p2_q [18];
  logic signed [AW-1:0]  adj3_q [9];
  logic signed [AW-1:0]  adjd_q [5][9];
  logic signed [TLW-1:0] tl3_q [6];
  logic signed [PW-1:0]  th3_q [6];
  logic signed [TW-1:0]  trp4_q [6];
  logic signed [TLW-1:0] ul4_q [9];
  logic signed [TLW-1:0] uh4_q [9];
  logic signed [DW-1:0]  pos_d, neg_d, pos5_q, neg5_q;
  logic signed [MW-1:0]  mt5_q [9];
  logic signed [DW-1:0]  det6_q, det7_q, det8_q;
  logic [DW-1:0]         s6_q;
  logic signed [TSW-1:0] t6_q [3];
  logic signed [TSW-1:0] t7_q [3];
  logic signed [TSW-1:0] t8_q [3];
  logic [NCH*EB-1:0]     sx;
  logic [2*EB-1:0]       pp7_q [NCH];
  logic [DW-1:0]         absdet7_q;
  logic                  dz7_q;
  logic [RW-1:0]         rhs, lhs;
  logic                  sing8_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[6:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q <= a_i;
    c1_q <= c_i;
    a2_q <= a1_q;
    c2_q <= c1_q;
    c3_q <= c2_q;
  end

  for (genvar k = 0; k < 9; k++) begin : g_adj
    always_ff @(posedge clk_i) begin
      p2_q[2*k]   <= PW'(a1_q[ami_pkg::ADJ_IDX[k][0]]) * PW'(a1_q[ami_pkg::ADJ_IDX[k][1]]);
      p2_q[2*k+1] <= PW'(a1_q[ami_pkg::ADJ_IDX[k][2]]) * PW'(a1_q[ami_pkg::ADJ_IDX[k][3]]);
      adj3_q[k]   <= ami_pkg::ADJ_NEG[k] ? (AW'(p2_q[2*k+1]) - AW'(p2_q[2*k]))
                                         : (AW'(p2_q[2*k]) - AW'(p2_q[2*k+1]));
    end
  end

  for (genvar m = 0; m < 6; m++) begin : g_trp
    always_ff @(posedge clk_i) begin
      tl3_q[m] <= TLW'($signed({1'b0, p2_q[ami_pkg::TRI_PROD[m]][W-1:0]}))
                * TLW'(a2_q[ami_pkg::TRI_ELEM[m]]);
      th3_q[m] <= PW'($signed(p2_q[ami_pkg::TRI_PROD[m]][PW-1:W]))
                * PW'(a2_q[ami_pkg::TRI_ELEM[m]]);
      trp4_q[m] <= ami_pkg::TRI_NEG[m] ? -((TW'(th3_q[m]) <<< W) + TW'(tl3_q[m]))
                                       : ((TW'(th3_q[m]) <<< W) + TW'(tl3_q[m]));
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_trk
    for (genvar j = 0; j < 3; j++) begin : g_trj
      always_ff @(posedge clk_i) begin
        ul4_q[3*k+j] <= TLW'($signed({1'b0, adj3_q[3*k+j][W-1:0]})) * TLW'(c3_q[k]);
        uh4_q[3*k+j] <= TLW'($signed(adj3_q[3*k+j][AW-1:W])) * TLW'(c3_q[k]);
        mt5_q[3*k+j] <= (MW'(uh4_q[3*k+j]) <<< W) + MW'(ul4_q[3*k+j]);
      end
    end
  end

  always_comb begin
    pos_d = '0;
    neg_d = '0;
    for (int m = 0; m < 6; m++) begin
      if (trp4_q[m][TW-1]) begin
        neg_d = neg_d + DW'(trp4_q[m]);
      end else begin
        pos_d = pos_d + DW'(trp4_q[m]);
      end
    end
  end

  assign sx = (NCH*EB)'(s6_q);

  always_ff @(posedge clk_i) begin
    adjd_q[0] <= adj3_q;
    for (int i = 1; i < 5; i++) begin
      adjd_q[i] <= adjd_q[i-1];
    end
    pos5_q <= pos_d;
    neg5_q <= neg_d;
    det6_q <= pos5_q + neg5_q;
    s6_q   <= DW'(pos5_q - neg5_q);
    for (int j = 0; j < 3; j++) begin
      t6_q[j] <= TSW'(mt5_q[j]) + TSW'(mt5_q[3+j]) + TSW'(mt5_q[6+j]);
    end
    for (int i = 0; i < NCH; i++) begin
      pp7_q[i] <= (2*EB)'(eps_i) * (2*EB)'(sx[i*EB +: EB]);
    end
    absdet7_q <= det6_q[DW-1] ? DW'(-det6_q) : DW'(det6_q);
    dz7_q     <= (det6_q == '0);
    det7_q    <= det6_q;
    t7_q      <= t6_q;
    det8_q    <= det7_q;
    t8_q      <= t7_q;
    sing8_q   <= dz7_q || (lhs < rhs);
  end

  always_comb begin
    rhs = '0;
    for (int i = 0; i < NCH; i++) begin
      rhs = rhs + (RW'(pp7_q[i]) << (i * EB));
    end
  end

  assign lhs = RW'(absdet7_q) << EB;

  assign out_valid_o = vld_q[7];
  assign sing_o      = sing8_q;
  assign adj_o       = adjd_q[4];
  assign t_o         = t8_q;
  assign det_o       = det8_q;

endmodule

[hw/rtl/ami_lane.sv]
// ----------------------------------------------------------------------------
// Affine matrix inverse divider lane
// Pipelined restoring division, one quotient bit per stage, with
// round to nearest and saturation.
// ----------------------------------------------------------------------------
module ami_lane #(
  parameter int unsigned WORD_BITS = ami_pkg::WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = ami_pkg::FRAC_BITS_DEF,
  localparam int unsigned NUMW = 3 * WORD_BITS + 2 * FRAC_BITS + 6,
  localparam int unsigned DW   = 3 * WORD_BITS + 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ami_pkg::ctl_t               ctl_i,
  input  logic signed [NUMW-1:0]      num_i,
  input  logic signed [DW-1:0]        det_i,
  output ami_pkg::ctl_t               ctl_o,
  output logic signed [WORD_BITS-1:0] q_o
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned XW = NUMW + 2;
  localparam int unsigned CW = XW + W + 1;

  logic [NUMW-1:0] num_mag;
  logic [DW-1:0]   det_mag;

  logic [XW-1:0]   x0_q;
  logic [DW:0]     d0_q;
  logic            sg0_q;
  ami_pkg::ctl_t   ctl0_q;

  logic [CW-1:0]   rem_q [W];
  logic [DW:0]     d_q   [W];
  logic [W-1:0]    qv_q  [W+1];
  logic            ovf_q [W+1];
  logic            sg_q  [W+1];
  ami_pkg::ctl_t   ctl_q [W+1];

  logic [W-1:0]    lim, mag;
  logic            sat;
  logic signed [W-1:0] res_q;
  ami_pkg::ctl_t   ctlf_q;

  assign num_mag = num_i[NUMW-1] ? NUMW'(-num_i) : NUMW'(num_i);
  assign det_mag = det_i[DW-1] ? DW'(-det_i) : DW'(det_i);

  always_ff @(posedge clk_i) begin
    x0_q     <= (XW'(num_mag) << 1) + XW'(det_mag);
    d0_q     <= (DW+1)'(det_mag) << 1;
    sg0_q    <= num_i[NUMW-1] ^ det_i[DW-1];
    rem_q[0] <= CW'(x0_q);
    d_q[0]   <= d0_q;
    qv_q[0]  <= '0;
    ovf_q[0] <= CW'(x0_q) >= (CW'(d0_q) << W);
    sg_q[0]  <= sg0_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl0_q   <= '0;
      ctl_q[0] <= '0;
    end else begin
      ctl0_q   <= ctl_i;
      ctl_q[0] <= ctl0_q;
    end
  end

  for (genvar s = 0; s < W; s++) begin : g_stage
    logic [CW-1:0] cand;
    logic          ge;

    assign cand = CW'(d_q[s]) << (W - 1 - s);
    assign ge   = rem_q[s] >= cand;

    always_ff @(posedge clk_i) begin
      qv_q[s+1]  <= {qv_q[s][W-2:0], ge};
      ovf_q[s+1] <= ovf_q[s];
      sg_q[s+1]  <= sg_q[s];
    end

    if (s < W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        rem_q[s+1] <= ge ? rem_q[s] - cand : rem_q[s];
        d_q[s+1]   <= d_q[s];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[s+1] <= '0;
      end else begin
        ctl_q[s+1] <= ctl_q[s];
      end
    end
  end

  assign lim = sg_q[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  assign sat = ovf_q[W] || (qv_q[W] > lim);
  assign mag = sat ? lim : qv_q[W];

  always_ff @(posedge clk_i) begin
    res_q <= sg_q[W] ? $signed(-mag) : $signed(mag);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctlf_q <= '0;
    end else begin
      ctlf_q <= ctl_q[W];
    end
  end

  assign ctl_o = ctlf_q;
  assign q_o   = res_q;

endmodule

[hw/rtl/ami_merge.sv]
// ----------------------------------------------------------------------------
// Affine matrix inverse merge stage
// Combines the three lane quotients into one result row.
// ----------------------------------------------------------------------------
module ami_merge #(
  parameter int unsigned WORD_BITS = ami_pkg::WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = ami_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ami_pkg::ctl_t               ctl_i,
  input  logic signed [WORD_BITS-1:0] q_i [ami_pkg::LANES],
  output logic                        valid_o,
  output logic [1:0]                  row_o,
  output logic signed [WORD_BITS-1:0] x_o,
  output logic signed [WORD_BITS-1:0] y_o,
  output logic signed [WORD_BITS-1:0] z_o,
  output logic signed [WORD_BITS-1:0] w_o,
  output logic                        sing_o,
  output logic                        last_o
);

  localparam logic [WORD_BITS-1:0] ONE = {{(WORD_BITS-1){1'b0}}, 1'b1} << FRAC_BITS;

  logic                        valid_q, sing_q, last_q;
  logic [1:0]                  row_q;
  logic signed [WORD_BITS-1:0] x_q, y_q, z_q, w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q  <= ctl_i.row;
    sing_q <= ctl_i.sing;
    last_q <= (ctl_i.row == ami_pkg::ROW_T);
    x_q    <= ctl_i.sing ? '0 : q_i[0];
    y_q    <= ctl_i.sing ? '0 : q_i[1];
    z_q    <= ctl_i.sing ? '0 : q_i[2];
    w_q    <= (!ctl_i.sing && ctl_i.row == ami_pkg::ROW_T) ? $signed(ONE) : '0;
  end

  assign valid_o = valid_q;
  assign row_o   = row_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign w_o     = w_q;
  assign sing_o  = sing_q;
  assign last_o  = last_q;

endmodule

[hw/rtl/affine_matrix4_inverse.sv]
// ----------------------------------------------------------------------------
// Affine 4x4 matrix inverse
// A request is taken when start is high and busy is low; busy then stays
// high while a row counter counts down; matrices may overlap in flight.
// Each request gives four result rows (x, y, z, translation) on
// consecutive cycles, each marked by result_valid_o for one cycle; the
// first row passes the front end, the holding registers, the lanes and
// the merge register. The receiver cannot stall the rows. The spacing of
// requests is set by the three division lanes, which take one row per
// cycle. rel_epsilon may be written through the cfg channel, which is
// always ready, while no request is in flight.
// ----------------------------------------------------------------------------
`include "affine_matrix4_inverse_assert.svh"

module affine_matrix4_inverse #(
  parameter int unsigned WORD_BITS = ami_pkg::WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = ami_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [WORD_BITS-1:0]        a_xx_i,
  input  logic signed [WORD_BITS-1:0]        a_xy_i,
  input  logic signed [WORD_BITS-1:0]        a_xz_i,
  input  logic signed [WORD_BITS-1:0]        a_yx_i,
  input  logic signed [WORD_BITS-1:0]        a_yy_i,
  input  logic signed [WORD_BITS-1:0]        a_yz_i,
  input  logic signed [WORD_BITS-1:0]        a_zx_i,
  input  logic signed [WORD_BITS-1:0]        a_zy_i,
  input  logic signed [WORD_BITS-1:0]        a_zz_i,
  input  logic signed [WORD_BITS-1:0]        shift_x_i,
  input  logic signed [WORD_BITS-1:0]        shift_y_i,
  input  logic signed [WORD_BITS-1:0]        shift_z_i,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ami_pkg::EPS_BITS-1:0]       cfg_data_i,
  output logic                               result_valid_o,
  output logic [1:0]                         row_index_o,
  output logic signed [WORD_BITS-1:0]        out_x_o,
  output logic signed [WORD_BITS-1:0]        out_y_o,
  output logic signed [WORD_BITS-1:0]        out_z_o,
  output logic signed [WORD_BITS-1:0]        out_w_o,
  output logic                               singular_o,
  output logic                               last_row_o
);

  localparam int unsigned NUMW = 3 * WORD_BITS + 2 * FRAC_BITS + 6;
  localparam int unsigned AW   = 2 * WORD_BITS + 1;
  localparam int unsigned DW   = 3 * WORD_BITS + 4;
  localparam int unsigned TSW  = 3 * WORD_BITS + 4;
  localparam int unsigned CNTW = $clog2(ami_pkg::ROWS);
  localparam int unsigned L    = ami_pkg::LANES;

  logic [ami_pkg::EPS_BITS-1:0] eps_q;
  logic [CNTW-1:0]              cnt_q;
  logic                         accept;

  logic signed [WORD_BITS-1:0]  a_in [9];
  logic signed [WORD_BITS-1:0]  c_in [3];

  logic                         fe_valid, fe_sing;
  logic signed [AW-1:0]         fe_adj [9];
  logic signed [TSW-1:0]        fe_t [3];
  logic signed [DW-1:0]         fe_det;

  logic signed [NUMW-1:0]       num_h_q [ami_pkg::ROWS][L];
  logic signed [DW-1:0]         det_h_q;
  logic                         sing_h_q;
  logic                         act_q;
  ami_pkg::row_e                row_q;
  ami_pkg::ctl_t                lane_ctl;

  ami_pkg::ctl_t                ln_ctl [L];
  logic signed [WORD_BITS-1:0]  ln_q [L];

  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign busy        = (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= ami_pkg::EPS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      eps_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (accept) begin
      cnt_q <= CNTW'(ami_pkg::ROWS - 1);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  assign a_in = '{a_xx_i, a_xy_i, a_xz_i, a_yx_i, a_yy_i, a_yz_i, a_zx_i, a_zy_i, a_zz_i};
  assign c_in = '{shift_x_i, shift_y_i, shift_z_i};

  ami_front #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (accept),
    .a_i         (a_in),
    .c_i         (c_in),
    .eps_i       (eps_q),
    .out_valid_o (fe_valid),
    .sing_o      (fe_sing),
    .adj_o       (fe_adj),
    .t_o         (fe_t),
    .det_o       (fe_det)
  );

  always_ff @(posedge clk_i) begin
    if (fe_valid) begin
      for (int r = 0; r < ami_pkg::ROWS - 1; r++) begin
        for (int j = 0; j < L; j++) begin
          num_h_q[r][j] <= NUMW'(fe_adj[3*r+j]) <<< (2 * FRAC_BITS);
        end
      end
      for (int j = 0; j < L; j++) begin
        num_h_q[ami_pkg::ROWS-1][j] <= (-NUMW'(fe_t[j])) <<< FRAC_BITS;
      end
      det_h_q  <= fe_det;
      sing_h_q <= fe_sing;
    end else if (act_q) begin
      for (int r = 0; r < ami_pkg::ROWS - 1; r++) begin
        num_h_q[r] <= num_h_q[r+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      row_q <= ami_pkg::ROW_X;
    end else if (fe_valid) begin
      act_q <= 1'b1;
      row_q <= ami_pkg::ROW_X;
    end else if (act_q) begin
      act_q <= (row_q != ami_pkg::ROW_T);
      row_q <= ami_pkg::row_e'(row_q + 2'd1);
    end
  end

  assign lane_ctl = '{valid: act_q, row: row_q, sing: sing_h_q};

  for (genvar j = 0; j < L; j++) begin : g_lane
    ami_lane #(
      .WORD_BITS (WORD_BITS),
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (lane_ctl),
      .num_i  (num_h_q[0][j]),
      .det_i  (det_h_q),
      .ctl_o  (ln_ctl[j]),
      .q_o    (ln_q[j])
    );
  end

  ami_merge #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ln_ctl[0]),
    .q_i     (ln_q),
    .valid_o (result_valid_o),
    .row_o   (row_index_o),
    .x_o     (out_x_o),
    .y_o     (out_y_o),
    .z_o     (out_z_o),
    .w_o     (out_w_o),
    .sing_o  (singular_o),
    .last_o  (last_row_o)
  );

  `AMI_ASSERT_NEXT(a_busy_after_start, start && !busy, busy)
  `AMI_ASSERT_NEXT(a_rows_in_order, result_valid_o && !last_row_o, result_valid_o && row_index_o == 2'($past(row_index_o) + 2'd1))
  `AMI_ASSERT_NOW(a_singular_zero, result_valid_o && singular_o, out_x_o == '0 && out_y_o == '0 && out_z_o == '0 && out_w_o == '0)

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// Affine 4x4 matrix inverse testbench
// Drives matrices in random bursts, predicts the four result rows of every
// accepted request with exact wide arithmetic, and checks each row as it
// appears. rel_epsilon is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ami_pkg::*;

  localparam int W = 32;
  localparam int F = 16;
  localparam int SETTLE_CYCLES = 12 + W + 16;
  localparam logic signed [W-1:0] ONE_Q = 1 <<< F;
  localparam logic signed [W-1:0] MAX_Q = 32'sh7fffffff;
  localparam logic signed [W-1:0] MIN_Q = 32'sh80000000;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic signed [W-1:0] m [9];
    logic signed [W-1:0] c [3];
  } mat_t;

  typedef struct {
    row_e                row;
    logic signed [W-1:0] x, y, z, w;
    logic                sing;
    logic                last;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [W-1:0] mat_a [9];
  logic signed [W-1:0] mat_c [3];
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [EPS_BITS-1:0] cfg_data_i = '0;
  logic result_valid_o;
  logic [1:0] row_index_o;
  logic signed [W-1:0] out_x_o, out_y_o, out_z_o, out_w_o;
  logic singular_o, last_row_o;

  logic [EPS_BITS-1:0] eps_model = EPS_RESET;
  mat_t mats_q [$];
  row_t rows_q [$];
  mat_t cur;
  int gap_left = 0;
  int burst_left = 0;
  bit failed = 0;

  initial begin
    for (int k = 0; k < 9; k++) mat_a[k] = '0;
    for (int k = 0; k < 3; k++) mat_c[k] = '0;
  end

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  affine_matrix4_inverse u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .a_xx_i(mat_a[0]), .a_xy_i(mat_a[1]), .a_xz_i(mat_a[2]),
    .a_yx_i(mat_a[3]), .a_yy_i(mat_a[4]), .a_yz_i(mat_a[5]),
    .a_zx_i(mat_a[6]), .a_zy_i(mat_a[7]), .a_zz_i(mat_a[8]),
    .shift_x_i(mat_c[0]), .shift_y_i(mat_c[1]), .shift_z_i(mat_c[2]),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .result_valid_o(result_valid_o), .row_index_o(row_index_o),
    .out_x_o(out_x_o), .out_y_o(out_y_o), .out_z_o(out_z_o), .out_w_o(out_w_o),
    .singular_o(singular_o), .last_row_o(last_row_o)
  );

  function automatic wide_t ext(logic signed [W-1:0] v);
    return wide_t'(v);
  endfunction

  function automatic wide_t wabs(wide_t v);
    return (v < 0) ? -v : v;
  endfunction

  // round to nearest, ties away from zero, then saturate
  function automatic logic signed [W-1:0] round_div(wide_t num, wide_t den);
    logic neg_res;
    wide_t q;
    neg_res = (num < 0) != (den < 0);
    q = (2 * wabs(num) + wabs(den)) / (2 * wabs(den));
    if (neg_res) begin
      if (q > wide_t'(64'h80000000)) q = wide_t'(64'h80000000);
      return W'(-q);
    end
    if (q > wide_t'(64'h7fffffff)) q = wide_t'(64'h7fffffff);
    return W'(q);
  endfunction

  function automatic wide_t minor2(mat_t t, int p, int q, int r, int s);
    return ext(t.m[p]) * ext(t.m[q]) - ext(t.m[r]) * ext(t.m[s]);
  endfunction

  task automatic predict_inverse(mat_t t);
    wide_t trip [6];
    wide_t cof [3][3];
    wide_t pos_sum, neg_sum, det, acc;
    logic signed [W-1:0] res [4][4];
    logic sing;
    row_t r;
    trip[0] = ext(t.m[0]) * ext(t.m[4]) * ext(t.m[8]);
    trip[1] = ext(t.m[1]) * ext(t.m[5]) * ext(t.m[6]);
    trip[2] = ext(t.m[2]) * ext(t.m[3]) * ext(t.m[7]);
    trip[3] = -(ext(t.m[2]) * ext(t.m[4]) * ext(t.m[6]));
    trip[4] = -(ext(t.m[1]) * ext(t.m[3]) * ext(t.m[8]));
    trip[5] = -(ext(t.m[0]) * ext(t.m[5]) * ext(t.m[7]));
    pos_sum = 0;
    neg_sum = 0;
    for (int k = 0; k < 6; k++) begin
      if (trip[k] < 0) neg_sum += trip[k];
      else pos_sum += trip[k];
    end
    det = pos_sum + neg_sum;
    sing = (det == 0) ||
           ((wabs(det) <<< 32) < wide_t'({224'd0, eps_model}) * (pos_sum - neg_sum));
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) res[i][j] = '0;
    if (!sing) begin
      cof[0][0] = minor2(t, 4, 8, 5, 7);
      cof[1][0] = -minor2(t, 3, 8, 5, 6);
      cof[2][0] = minor2(t, 3, 7, 4, 6);
      cof[0][1] = -minor2(t, 1, 8, 2, 7);
      cof[1][1] = minor2(t, 0, 8, 2, 6);
      cof[2][1] = -minor2(t, 0, 7, 1, 6);
      cof[0][2] = minor2(t, 1, 5, 2, 4);
      cof[1][2] = -minor2(t, 0, 5, 2, 3);
      cof[2][2] = minor2(t, 0, 4, 1, 3);
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) res[i][j] = round_div(cof[i][j] <<< (2 * F), det);
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += ext(t.c[k]) * cof[k][j];
        res[3][j] = round_div((-acc) <<< F, det);
      end
      res[3][3] = ONE_Q;
    end
    for (int i = 0; i < 4; i++) begin
      r.row = row_e'(i);
      r.x = res[i][0];
      r.y = res[i][1];
      r.z = res[i][2];
      r.w = res[i][3];
      r.sing = sing;
      r.last = (i == 3);
      rows_q.push_back(r);
    end
  endtask

  // driver: bursts of requests separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) predict_inverse(cur);
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (mats_q.size() > 0) begin
          cur = mats_q.pop_front();
          for (int k = 0; k < 9; k++) mat_a[k] <= cur.m[k];
          for (int k = 0; k < 3; k++) mat_c[k] <= cur.c[k];
          start <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (rows_q.size() == 0) begin
        $error("unexpected result row %0d", row_index_o);
        failed = 1;
      end else begin
        row_t e;
        e = rows_q.pop_front();
        if (row_index_o !== e.row) begin
          $error("row_index: expected %0d, got %0d", e.row, row_index_o);
          failed = 1;
        end
        if (out_x_o !== e.x) begin
          $error("out_x: expected %h, got %h", e.x, out_x_o);
          failed = 1;
        end
        if (out_y_o !== e.y) begin
          $error("out_y: expected %h, got %h", e.y, out_y_o);
          failed = 1;
        end
        if (out_z_o !== e.z) begin
          $error("out_z: expected %h, got %h", e.z, out_z_o);
          failed = 1;
        end
        if (out_w_o !== e.w) begin
          $error("out_w: expected %h, got %h", e.w, out_w_o);
          failed = 1;
        end
        if (singular_o !== e.sing) begin
          $error("singular: expected %b, got %b", e.sing, singular_o);
          failed = 1;
        end
        if (last_row_o !== e.last) begin
          $error("last_row: expected %b, got %b", e.last, last_row_o);
          failed = 1;
        end
      end
    end
  end

  function automatic mat_t diag_mat(logic signed [W-1:0] d0, logic signed [W-1:0] d1,
                                    logic signed [W-1:0] d2, logic signed [W-1:0] sh);
    mat_t t;
    for (int k = 0; k < 9; k++) t.m[k] = '0;
    t.m[0] = d0;
    t.m[4] = d1;
    t.m[8] = d2;
    for (int k = 0; k < 3; k++) t.c[k] = sh;
    return t;
  endfunction

  function automatic logic signed [W-1:0] small_q();
    return W'($signed($urandom_range(0, 8 << F)) - (4 << F));
  endfunction

  function automatic mat_t random_mat();
    mat_t t;
    int mode;
    mode = $urandom_range(0, 9);
    for (int k = 0; k < 9; k++) t.m[k] = small_q();
    for (int k = 0; k < 3; k++) t.c[k] = ($urandom_range(0, 3) == 0) ? $urandom : small_q();
    case (mode)
      0, 1: begin
        for (int k = 0; k < 9; k++) t.m[k] = $urandom;
        for (int k = 0; k < 3; k++) t.c[k] = $urandom;
      end
      2: begin
        for (int k = 0; k < 3; k++) t.m[6 + k] = t.m[k] + t.m[3 + k];
      end
      3: begin
        for (int k = 0; k < 9; k++) t.m[k] = W'($signed($urandom_range(0, 64)) - 32);
      end
      4: begin
        t.m[3] = t.m[0] + W'($urandom_range(0, 3));
        t.m[4] = t.m[1];
        t.m[5] = t.m[2] + W'($urandom_range(0, 1));
      end
      default: begin
        t.m[0] += 16 << F;
        t.m[4] -= 16 << F;
        t.m[8] += 16 << F;
      end
    endcase
    return t;
  endfunction

  task automatic wait_idle();
    do @(posedge clk_i);
    while (mats_q.size() != 0 || start || rows_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_eps(logic [EPS_BITS-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    eps_model = v;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random(int n);
    for (int k = 0; k < n; k++) mats_q.push_back(random_mat());
    wait_idle();
  endtask

  initial begin
    mat_t t;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    mats_q.push_back(diag_mat(ONE_Q, ONE_Q, ONE_Q, '0));
    mats_q.push_back(diag_mat('0, '0, '0, '0));
    mats_q.push_back(diag_mat(MAX_Q, MAX_Q, MAX_Q, MAX_Q));
    mats_q.push_back(diag_mat(MIN_Q, MIN_Q, MIN_Q, MIN_Q));
    mats_q.push_back(diag_mat(MIN_Q, MAX_Q, MIN_Q, MAX_Q));
    mats_q.push_back(diag_mat(1, 1, 1, MAX_Q));
    mats_q.push_back(diag_mat(-1, 1, 1, MIN_Q));
    mats_q.push_back(diag_mat(2 << F, -(4 << F), ONE_Q >>> 1, 3 << F));
    mats_q.push_back(diag_mat(ONE_Q, ONE_Q, 3, ONE_Q));
    mats_q.push_back(diag_mat(-1, -1, -1, -1));
    for (int k = 0; k < 9; k++) t.m[k] = (k % 2) ? MIN_Q : MAX_Q;
    for (int k = 0; k < 3; k++) t.c[k] = MIN_Q;
    mats_q.push_back(t);
    for (int k = 0; k < 9; k++) t.m[k] = ONE_Q * (k + 1);
    mats_q.push_back(t);
    t.m[8] = ONE_Q * 9 + 1;
    mats_q.push_back(t);
    t.m[8] = ONE_Q * 9 + 1000;
    mats_q.push_back(t);
    for (int k = 0; k < 9; k++) t.m[k] = '0;
    t.m[1] = ONE_Q;
    t.m[5] = -ONE_Q;
    t.m[6] = 2 << F;
    t.c[0] = MAX_Q;
    t.c[1] = 1;
    t.c[2] = -(7 << F);
    mats_q.push_back(t);
    wait_idle();
    run_random(60);

    write_eps('0);
    mats_q.push_back(diag_mat(ONE_Q, ONE_Q, 3, ONE_Q));
    run_random(60);

    write_eps('1);
    mats_q.push_back(diag_mat(ONE_Q, ONE_Q, ONE_Q, ONE_Q));
    run_random(60);

    write_eps($urandom);
    run_random(60);

    write_eps(EPS_RESET);
    run_random(60);

    if (!failed) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[affine_matrix4_inverse.f]
+incdir+hw/rtl
hw/rtl/ami_pkg.sv
hw/rtl/ami_front.sv
hw/rtl/ami_lane.sv
hw/rtl/ami_merge.sv
hw/rtl/affine_matrix4_inverse.sv
tb/tb.sv
